>>> src/gpsr_pkg.sv
package gpsr_pkg;

    // default fraction widths
    localparam int DEF_TRIG_FRAC_BITS = 14;
    localparam int DEF_OUT_FRAC_BITS  = 8;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // field widths
    localparam int COORD_W   = 12;
    localparam int HEIGHT_W  = 16;
    localparam int TAG_W     = 12;
    localparam int SPACING_W = 8;
    localparam int ORIGIN_W  = 16;
    localparam int GRID_W    = 13;
    localparam int TRIG_IN_W = 16;
    localparam int SCREEN_W  = 32;
    localparam int SHEIGHT_W = 24;

    // register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SPACING     = 3'd0,
        REG_ORIGIN_X    = 3'd1,
        REG_ORIGIN_Y    = 3'd2,
        REG_GRID_WIDTH  = 3'd3,
        REG_GRID_HEIGHT = 3'd4,
        REG_COS_THETA   = 3'd5,
        REG_SIN_THETA   = 3'd6
    } cfg_reg_t;

endpackage

>>> src/grid_point_scale_rotate_project_unit.sv
// Height-map point projector. Each request carries one grid point (x, y,
// height) plus its row/column tag; the point is scaled by the spacing,
// rotated about the grid centre with the configured cos/sin words, lifted
// by the scaled height and moved to the screen origin. The unit is a
// five-stage pipeline (scale, centre offset, rotation multiply, combine,
// round/saturate): a request is taken in every cycle, busy stays low, and
// each result appears on the result ports with done high for exactly one
// cycle, after its request has passed all the stages. Results come out in
// request order and cannot be held off, so the receiver must take them as
// they come. Write the configuration registers only when no request is in
// flight; a write takes effect at the next clock edge.
module grid_point_scale_rotate_project_unit #(
    parameter int TRIG_FRAC_BITS = gpsr_pkg::DEF_TRIG_FRAC_BITS,
    parameter int OUT_FRAC_BITS  = gpsr_pkg::DEF_OUT_FRAC_BITS
) (
    input  logic                                   clk,
    input  logic                                   rst_n,

    // configuration write port
    input  logic                                   cfg_write,
    input  logic [gpsr_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [gpsr_pkg::CFG_DATA_W-1:0]        cfg_data,

    // request
    input  logic                                   start,
    output logic                                   busy,
    input  logic [gpsr_pkg::COORD_W-1:0]           point_x,
    input  logic [gpsr_pkg::COORD_W-1:0]           point_y,
    input  logic signed [gpsr_pkg::HEIGHT_W-1:0]   point_height,
    input  logic [gpsr_pkg::TAG_W-1:0]             grid_row,
    input  logic [gpsr_pkg::TAG_W-1:0]             grid_col,

    // result
    output logic                                   done,
    output logic signed [gpsr_pkg::SCREEN_W-1:0]   screen_x,
    output logic signed [gpsr_pkg::SCREEN_W-1:0]   screen_y,
    output logic signed [gpsr_pkg::SHEIGHT_W-1:0]  scaled_height,
    output logic [gpsr_pkg::TAG_W-1:0]             out_row,
    output logic [gpsr_pkg::TAG_W-1:0]             out_col
);

    import gpsr_pkg::*;

    // stored trig width: wide enough for the reset value of one
    localparam int TRIG_W  = (TRIG_FRAC_BITS + 2 > TRIG_IN_W) ? TRIG_FRAC_BITS + 2 : TRIG_IN_W;
    localparam int SCL_W   = COORD_W + SPACING_W;          // scaled x / y
    localparam int CTR_W   = GRID_W + SPACING_W;           // doubled centre
    localparam int DIFF_W  = CTR_W + 1;                    // doubled offset from centre
    localparam int OFFX_W  = CTR_W + 2;                    // doubled centre x + 2*origin x
    localparam int OFFY_W  = SHEIGHT_W + 3;                // doubled centre y + 2*origin y - 2*height
    localparam int PROD_W  = DIFF_W + TRIG_W;
    localparam int SUM_A   = PROD_W + 1;
    localparam int SUM_B   = OFFY_W + TRIG_FRAC_BITS;
    localparam int F_W     = ((SUM_A > SUM_B) ? SUM_A : SUM_B) + 1;
    localparam int SHIFT   = TRIG_FRAC_BITS + 1 - OUT_FRAC_BITS;
    localparam int SH_POS  = (SHIFT > 0) ? SHIFT : 1;
    localparam int SH_NEG  = (SHIFT < 0) ? -SHIFT : 0;
    localparam int R_W     = F_W + SH_NEG + 1;

    localparam logic signed [F_W:0]   HALF_LSB = (F_W + 1)'(1) <<< (SH_POS - 1);
    localparam logic signed [R_W-1:0] SAT_HI   = R_W'(32'sh7fffffff);
    localparam logic signed [R_W-1:0] SAT_LO   = R_W'(32'sh80000000);

    // configuration registers
    logic [SPACING_W-1:0]        spacing_reg;
    logic signed [ORIGIN_W-1:0]  scr_ofs_x_reg;
    logic signed [ORIGIN_W-1:0]  scr_ofs_y_reg;
    logic [GRID_W-1:0]           grid_width_reg;
    logic [GRID_W-1:0]           grid_height_reg;
    logic signed [TRIG_W-1:0]    cos_reg;
    logic signed [TRIG_W-1:0]    sin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spacing_reg     <= SPACING_W'(1);
            scr_ofs_x_reg   <= '0;
            scr_ofs_y_reg   <= '0;
            grid_width_reg  <= GRID_W'(1);
            grid_height_reg <= GRID_W'(1);
            cos_reg         <= TRIG_W'(1) << TRIG_FRAC_BITS;
            sin_reg         <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_SPACING:     spacing_reg     <= cfg_data[SPACING_W-1:0];
                REG_ORIGIN_X:    scr_ofs_x_reg   <= $signed(cfg_data[ORIGIN_W-1:0]);
                REG_ORIGIN_Y:    scr_ofs_y_reg   <= $signed(cfg_data[ORIGIN_W-1:0]);
                REG_GRID_WIDTH:  grid_width_reg  <= cfg_data[GRID_W-1:0];
                REG_GRID_HEIGHT: grid_height_reg <= cfg_data[GRID_W-1:0];
                REG_COS_THETA:   cos_reg <= TRIG_W'($signed(cfg_data[TRIG_IN_W-1:0]));
                REG_SIN_THETA:   sin_reg <= TRIG_W'($signed(cfg_data[TRIG_IN_W-1:0]));
                default:         ;
            endcase
        end
    end

    // the pipeline never stalls
    assign busy = 1'b0;

    // stage valid bits
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // stage 1: scale by spacing, doubled centre
    logic [SCL_W-1:0]            sx1_reg, sy1_reg;
    logic signed [SHEIGHT_W-1:0] sz1_reg;
    logic [CTR_W-1:0]            cx1_reg, cy1_reg;
    logic [TAG_W-1:0]            row1_reg, col1_reg;

    // stage 2: offsets from centre in half units
    logic signed [DIFF_W-1:0]    dx2_reg, dy2_reg;
    logic signed [OFFX_W-1:0]    offx2_reg;
    logic signed [OFFY_W-1:0]    offy2_reg;
    logic signed [SHEIGHT_W-1:0] sz2_reg;
    logic [TAG_W-1:0]            row2_reg, col2_reg;

    // stage 3: rotation products
    logic signed [PROD_W-1:0]    xc3_reg, ys3_reg, xs3_reg, yc3_reg;
    logic signed [OFFX_W-1:0]    offx3_reg;
    logic signed [OFFY_W-1:0]    offy3_reg;
    logic signed [SHEIGHT_W-1:0] sz3_reg;
    logic [TAG_W-1:0]            row3_reg, col3_reg;

    // stage 4: exact sums in units of 2^-(trig frac + 1)
    logic signed [F_W-1:0]       fx4_reg, fy4_reg;
    logic signed [SHEIGHT_W-1:0] sz4_reg;
    logic [TAG_W-1:0]            row4_reg, col4_reg;

    // stage 5: rounded, saturated outputs
    logic signed [SCREEN_W-1:0]  sx5_reg, sy5_reg;
    logic signed [SCREEN_W-1:0]  sx5_next, sy5_next;
    logic signed [SHEIGHT_W-1:0] sz5_reg;
    logic [TAG_W-1:0]            row5_reg, col5_reg;

    // round half up (or widen exactly), then clamp to 32 bits
    function automatic logic signed [SCREEN_W-1:0] round_sat(input logic signed [F_W-1:0] v);
        logic signed [F_W:0]   biased;
        logic signed [R_W-1:0] r;
        begin
            biased = (F_W + 1)'(v) + HALF_LSB;
            if (SHIFT > 0)
                r = R_W'(biased >>> SH_POS);
            else
                r = R_W'(v) <<< SH_NEG;
            if (r > SAT_HI)
                round_sat = 32'sh7fffffff;
            else if (r < SAT_LO)
                round_sat = 32'sh80000000;
            else
                round_sat = r[SCREEN_W-1:0];
        end
    endfunction

    always_comb
    begin
        sx5_next = round_sat(fx4_reg);
        sy5_next = round_sat(fy4_reg);
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        // stage 1
        sx1_reg  <= SCL_W'(point_x) * SCL_W'(spacing_reg);
        sy1_reg  <= SCL_W'(point_y) * SCL_W'(spacing_reg);
        sz1_reg  <= SHEIGHT_W'(point_height) * SHEIGHT_W'($signed({1'b0, spacing_reg}));
        cx1_reg  <= CTR_W'(grid_width_reg) * CTR_W'(spacing_reg);
        cy1_reg  <= CTR_W'(grid_height_reg) * CTR_W'(spacing_reg);
        row1_reg <= grid_row;
        col1_reg <= grid_col;

        // stage 2
        dx2_reg   <= $signed({1'b0, sx1_reg, 1'b0}) - $signed({1'b0, cx1_reg});
        dy2_reg   <= $signed({1'b0, sy1_reg, 1'b0}) - $signed({1'b0, cy1_reg});
        offx2_reg <= OFFX_W'($signed({1'b0, cx1_reg}))
                   + OFFX_W'($signed({scr_ofs_x_reg, 1'b0}));
        offy2_reg <= OFFY_W'($signed({1'b0, cy1_reg}))
                   + OFFY_W'($signed({scr_ofs_y_reg, 1'b0}))
                   - OFFY_W'($signed({sz1_reg, 1'b0}));
        sz2_reg   <= sz1_reg;
        row2_reg  <= row1_reg;
        col2_reg  <= col1_reg;

        // stage 3
        xc3_reg   <= PROD_W'(dx2_reg) * PROD_W'(cos_reg);
        ys3_reg   <= PROD_W'(dy2_reg) * PROD_W'(sin_reg);
        xs3_reg   <= PROD_W'(dx2_reg) * PROD_W'(sin_reg);
        yc3_reg   <= PROD_W'(dy2_reg) * PROD_W'(cos_reg);
        offx3_reg <= offx2_reg;
        offy3_reg <= offy2_reg;
        sz3_reg   <= sz2_reg;
        row3_reg  <= row2_reg;
        col3_reg  <= col2_reg;

        // stage 4
        fx4_reg  <= F_W'(xc3_reg) - F_W'(ys3_reg) + (F_W'(offx3_reg) <<< TRIG_FRAC_BITS);
        fy4_reg  <= F_W'(xs3_reg) + F_W'(yc3_reg) + (F_W'(offy3_reg) <<< TRIG_FRAC_BITS);
        sz4_reg  <= sz3_reg;
        row4_reg <= row3_reg;
        col4_reg <= col3_reg;

        // stage 5
        sx5_reg  <= sx5_next;
        sy5_reg  <= sy5_next;
        sz5_reg  <= sz4_reg;
        row5_reg <= row4_reg;
        col5_reg <= col4_reg;
    end

    assign done          = v5_reg;
    assign screen_x      = sx5_reg;
    assign screen_y      = sy5_reg;
    assign scaled_height = sz5_reg;
    assign out_row       = row5_reg;
    assign out_col       = col5_reg;

endmodule
